[src/bmm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_pkg
// Types, codes and sizes shared by the Barrett modular multiplier modules.
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int LIMB_BITS  = 32;
  localparam int MAX_LIMBS  = 16;
  localparam int MU_DEPTH   = MAX_LIMBS + 1;
  localparam int WIDE_DEPTH = 2 * MAX_LIMBS + 2;
  localparam int CFG_W      = 5;
  localparam int CNT_W      = $clog2(MAX_LIMBS + 2);
  localparam int IDX_W      = $clog2(MAX_LIMBS);
  localparam int MU_IDX_W   = $clog2(MU_DEPTH);
  localparam int ADDR_W     = $clog2(WIDE_DEPTH);
  localparam int LOG_LB     = $clog2(LIMB_BITS);
  localparam int BITS_W     = $clog2(MU_DEPTH * LIMB_BITS + 1);

  localparam logic [2:0] OP_LOAD_N  = 3'd0;
  localparam logic [2:0] OP_LOAD_MU = 3'd1;
  localparam logic [2:0] OP_LOAD_A  = 3'd2;
  localparam logic [2:0] OP_LOAD_B  = 3'd3;
  localparam logic [2:0] OP_START   = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  limb_index;
    logic [31:0] limb_value;
  } item_t;

  typedef struct packed {
    logic [31:0] result_limb;
    logic [3:0]  result_index;
    logic        last_limb;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_ISSUE,
    ST_MAC_FETCH,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_MAC_CARRY,
    ST_SUB_ISSUE,
    ST_SUB_CALC,
    ST_DIV_INIT,
    ST_DIV_SHIFT,
    ST_DIV_SUB,
    ST_DIV_SEL,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PASS_AB,
    PASS_MU,
    PASS_N
  } pass_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_START,
    DP_ISSUE,
    DP_FETCH,
    DP_MUL,
    DP_ACC,
    DP_CARRY,
    DP_SUB_ISSUE,
    DP_SUB_CALC,
    DP_DIV_INIT,
    DP_DIV_SHIFT,
    DP_DIV_SUB,
    DP_DIV_SEL,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    pass_t            pass;
    logic [CNT_W-1:0] i;
    logic [CNT_W-1:0] j;
    logic [CNT_W-1:0] k;
    logic             carry_en;
    item_t            item;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_nonzero;
  } dp_status_t;

endpackage
`default_nettype wire

[src/bmm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_datapath
// Limb stores, product memories, shared limb multiplier and the bit-serial
// remainder unit, all driven by controller commands.
// ----------------------------------------------------------------------------
module bmm_datapath (
  input  wire                 clk,
  input  bmm_pkg::ctrl_cmd_t  cmd,
  output bmm_pkg::dp_status_t status,
  output logic                done,
  output bmm_pkg::result_t    result
);

  localparam int LB = bmm_pkg::LIMB_BITS;
  localparam int AW = bmm_pkg::ADDR_W;

  logic [LB-1:0] a_store  [bmm_pkg::MAX_LIMBS];
  logic [LB-1:0] b_store  [bmm_pkg::MAX_LIMBS];
  logic [LB-1:0] n_store  [bmm_pkg::MAX_LIMBS];
  logic [LB-1:0] mu_store [bmm_pkg::MU_DEPTH];
  logic [LB-1:0] prod_mem [bmm_pkg::WIDE_DEPTH];
  logic [LB-1:0] wide_mem [bmm_pkg::WIDE_DEPTH];
  logic [LB-1:0] t_reg    [bmm_pkg::MU_DEPTH];
  logic [LB-1:0] dvd      [bmm_pkg::MU_DEPTH];
  logic [LB-1:0] part     [bmm_pkg::MU_DEPTH];
  logic [LB-1:0] diff     [bmm_pkg::MU_DEPTH];

  logic [LB-1:0]   prod_rd;
  logic [LB-1:0]   wide_rd;
  logic [LB-1:0]   op_a;
  logic [LB-1:0]   op_b;
  logic [LB-1:0]   acc;
  logic [LB-1:0]   carry;
  logic [2*LB-1:0] mul_q;
  logic            borrow;
  logic            n_nonzero;

  logic [AW-1:0]   ix;
  logic [AW-1:0]   jx;
  logic [AW-1:0]   kx;
  logic [AW-1:0]   ij;
  logic [AW-1:0]   na;
  logic [AW-1:0]   carry_addr;
  logic [AW-1:0]   prod_raddr;
  logic [AW-1:0]   wide_raddr;
  logic [2*LB-1:0] mac_sum;
  logic [LB:0]     sub_diff;
  logic [LB:0]     div_diff;
  logic [LB-1:0]   nx;
  logic            top_bit;

  always_comb begin
    ix = AW'(cmd.i);
    jx = AW'(cmd.j);
    kx = AW'(cmd.k);
    ij = ix + jx;
    na = (cmd.pass == bmm_pkg::PASS_AB) ? kx : kx + AW'(1);
    carry_addr = ix + na;
    prod_raddr = (cmd.pass == bmm_pkg::PASS_AB) ? ij :
                 (cmd.pass == bmm_pkg::PASS_MU) ? kx - AW'(1) + jx : jx;
    wide_raddr = (cmd.pass == bmm_pkg::PASS_MU) ? ij : kx + AW'(1) + jx;
    mac_sum = mul_q + {{LB{1'b0}}, acc} + {{LB{1'b0}}, carry};
    sub_diff = {1'b0, prod_rd} - {1'b0, t_reg[cmd.j]} - {{LB{1'b0}}, borrow};
    nx = (cmd.j < cmd.k) ? n_store[cmd.j[bmm_pkg::IDX_W-1:0]] : '0;
    div_diff = {1'b0, part[cmd.j]} - {1'b0, nx} - {{LB{1'b0}}, borrow};
    top_bit = dvd[cmd.k][LB-1];
  end

  always_ff @(posedge clk) begin
    prod_rd <= prod_mem[prod_raddr];
    if (cmd.pass == bmm_pkg::PASS_AB) begin
      if (cmd.op == bmm_pkg::DP_ACC) begin
        prod_mem[ij] <= mac_sum[LB-1:0];
      end else if (cmd.op == bmm_pkg::DP_CARRY && cmd.carry_en) begin
        prod_mem[carry_addr] <= carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    wide_rd <= wide_mem[wide_raddr];
    if (cmd.pass == bmm_pkg::PASS_MU) begin
      if (cmd.op == bmm_pkg::DP_ACC) begin
        wide_mem[ij] <= mac_sum[LB-1:0];
      end else if (cmd.op == bmm_pkg::DP_CARRY && cmd.carry_en) begin
        wide_mem[carry_addr] <= carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bmm_pkg::DP_LOAD: begin
        unique case (cmd.item.opcode)
          bmm_pkg::OP_LOAD_N: begin
            if (cmd.item.limb_index < bmm_pkg::MAX_LIMBS) begin
              n_store[cmd.item.limb_index[bmm_pkg::IDX_W-1:0]] <= cmd.item.limb_value;
            end
          end
          bmm_pkg::OP_LOAD_MU: begin
            if (cmd.item.limb_index < bmm_pkg::MU_DEPTH) begin
              mu_store[cmd.item.limb_index[bmm_pkg::MU_IDX_W-1:0]] <= cmd.item.limb_value;
            end
          end
          bmm_pkg::OP_LOAD_A: begin
            if (cmd.item.limb_index < bmm_pkg::MAX_LIMBS) begin
              a_store[cmd.item.limb_index[bmm_pkg::IDX_W-1:0]] <= cmd.item.limb_value;
            end
          end
          bmm_pkg::OP_LOAD_B: begin
            if (cmd.item.limb_index < bmm_pkg::MAX_LIMBS) begin
              b_store[cmd.item.limb_index[bmm_pkg::IDX_W-1:0]] <= cmd.item.limb_value;
            end
          end
          default: begin
          end
        endcase
      end
      bmm_pkg::DP_START: begin
        carry     <= '0;
        borrow    <= 1'b0;
        n_nonzero <= 1'b0;
      end
      bmm_pkg::DP_FETCH: begin
        unique case (cmd.pass)
          bmm_pkg::PASS_AB: begin
            op_a <= a_store[cmd.j[bmm_pkg::IDX_W-1:0]];
            op_b <= b_store[cmd.i[bmm_pkg::IDX_W-1:0]];
            acc  <= (cmd.i == '0) ? '0 : prod_rd;
          end
          bmm_pkg::PASS_MU: begin
            op_a <= prod_rd;
            op_b <= mu_store[cmd.i];
            acc  <= (cmd.i == '0) ? '0 : wide_rd;
          end
          default: begin
            op_a <= wide_rd;
            op_b <= n_store[cmd.i[bmm_pkg::IDX_W-1:0]];
            acc  <= (cmd.i == '0) ? '0 : t_reg[ij[bmm_pkg::MU_IDX_W-1:0]];
          end
        endcase
      end
      bmm_pkg::DP_MUL: begin
        mul_q <= op_a * op_b;
      end
      bmm_pkg::DP_ACC: begin
        carry <= mac_sum[2*LB-1:LB];
        if (cmd.pass == bmm_pkg::PASS_N) begin
          t_reg[ij[bmm_pkg::MU_IDX_W-1:0]] <= mac_sum[LB-1:0];
        end
      end
      bmm_pkg::DP_CARRY: begin
        carry <= '0;
        if (cmd.pass == bmm_pkg::PASS_N && cmd.carry_en) begin
          t_reg[carry_addr[bmm_pkg::MU_IDX_W-1:0]] <= carry;
        end
      end
      bmm_pkg::DP_SUB_CALC: begin
        dvd[cmd.j] <= sub_diff[LB-1:0];
        borrow     <= sub_diff[LB];
        if (cmd.j < cmd.k && n_store[cmd.j[bmm_pkg::IDX_W-1:0]] != '0) begin
          n_nonzero <= 1'b1;
        end
      end
      bmm_pkg::DP_DIV_INIT: begin
        for (int m = 0; m < bmm_pkg::MU_DEPTH; m++) begin
          part[m] <= '0;
        end
      end
      bmm_pkg::DP_DIV_SHIFT: begin
        borrow <= 1'b0;
        part[0] <= {part[0][LB-2:0], top_bit};
        dvd[0]  <= {dvd[0][LB-2:0], 1'b0};
        for (int m = 1; m < bmm_pkg::MU_DEPTH; m++) begin
          part[m] <= {part[m][LB-2:0], part[m-1][LB-1]};
          dvd[m]  <= {dvd[m][LB-2:0], dvd[m-1][LB-1]};
        end
      end
      bmm_pkg::DP_DIV_SUB: begin
        diff[cmd.j] <= div_diff[LB-1:0];
        borrow      <= div_diff[LB];
      end
      bmm_pkg::DP_DIV_SEL: begin
        if (!borrow) begin
          for (int m = 0; m < bmm_pkg::MU_DEPTH; m++) begin
            if (bmm_pkg::CNT_W'(m) <= cmd.k) begin
              part[m] <= diff[m];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    done                = (cmd.op == bmm_pkg::DP_EMIT);
    result.result_limb  = n_nonzero ? part[cmd.j] : dvd[cmd.j];
    result.result_index = cmd.j[bmm_pkg::IDX_W-1:0];
    result.last_limb    = (cmd.j == cmd.k - bmm_pkg::CNT_W'(1));
    status.n_nonzero    = n_nonzero;
  end

endmodule
`default_nettype wire

[src/bmm_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_controller
// Sequencer for the three limb products, the final subtraction, the
// bit-serial remainder and the result run; holds the limb count register.
// ----------------------------------------------------------------------------
module bmm_controller (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  bmm_pkg::item_t             item,
  input  wire                        cfg_we,
  input  wire [bmm_pkg::CFG_W-1:0]   cfg_data,
  input  bmm_pkg::dp_status_t        status,
  output logic                       busy,
  output bmm_pkg::ctrl_cmd_t         cmd
);

  localparam int AW = bmm_pkg::ADDR_W;
  localparam int CW = bmm_pkg::CNT_W;
  localparam int BW = bmm_pkg::BITS_W;

  bmm_pkg::state_t        state, state_next;
  bmm_pkg::pass_t         pass, pass_next;
  logic [CW-1:0]          i, i_next;
  logic [CW-1:0]          j, j_next;
  logic [BW-1:0]          bits_left, bits_left_next;
  logic [bmm_pkg::CFG_W-1:0] k_cfg;

  logic [CW-1:0] k;
  logic [AW-1:0] kx;
  logic [AW-1:0] na;
  logic [AW-1:0] nb;
  logic [AW-1:0] nout;
  logic [AW-1:0] ij;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmm_pkg::ST_IDLE;
      pass      <= bmm_pkg::PASS_AB;
      i         <= '0;
      j         <= '0;
      bits_left <= '0;
      k_cfg     <= bmm_pkg::CFG_W'(bmm_pkg::MAX_LIMBS);
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      i         <= i_next;
      j         <= j_next;
      bits_left <= bits_left_next;
      if (cfg_we) begin
        k_cfg <= cfg_data;
      end
    end
  end

  always_comb begin
    if (k_cfg == '0) begin
      k = CW'(1);
    end else if (k_cfg > bmm_pkg::MAX_LIMBS) begin
      k = CW'(bmm_pkg::MAX_LIMBS);
    end else begin
      k = CW'(k_cfg);
    end
    kx = AW'(k);
    unique case (pass)
      bmm_pkg::PASS_AB: begin
        na = kx;
        nb = kx;
        nout = kx + kx;
      end
      bmm_pkg::PASS_MU: begin
        na = kx + AW'(1);
        nb = kx + AW'(1);
        nout = kx + kx + AW'(2);
      end
      default: begin
        na = kx + AW'(1);
        nb = kx;
        nout = kx + AW'(1);
      end
    endcase
    ij = AW'(i) + AW'(j);
  end

  always_comb begin
    state_next     = state;
    pass_next      = pass;
    i_next         = i;
    j_next         = j;
    bits_left_next = bits_left;
    busy           = (state != bmm_pkg::ST_IDLE);
    cmd.op         = bmm_pkg::DP_NOP;
    cmd.pass       = pass;
    cmd.i          = i;
    cmd.j          = j;
    cmd.k          = k;
    cmd.carry_en   = (AW'(i) + na < nout);
    cmd.item       = item;
    unique case (state)
      bmm_pkg::ST_IDLE: begin
        if (start) begin
          if (item.opcode == bmm_pkg::OP_START) begin
            cmd.op     = bmm_pkg::DP_START;
            pass_next  = bmm_pkg::PASS_AB;
            i_next     = '0;
            j_next     = '0;
            state_next = bmm_pkg::ST_MAC_ISSUE;
          end else begin
            cmd.op = bmm_pkg::DP_LOAD;
          end
        end
      end
      bmm_pkg::ST_MAC_ISSUE: begin
        if (AW'(j) < na && ij < nout) begin
          cmd.op     = bmm_pkg::DP_ISSUE;
          state_next = bmm_pkg::ST_MAC_FETCH;
        end else begin
          state_next = bmm_pkg::ST_MAC_CARRY;
        end
      end
      bmm_pkg::ST_MAC_FETCH: begin
        cmd.op     = bmm_pkg::DP_FETCH;
        state_next = bmm_pkg::ST_MAC_MUL;
      end
      bmm_pkg::ST_MAC_MUL: begin
        cmd.op     = bmm_pkg::DP_MUL;
        state_next = bmm_pkg::ST_MAC_ACC;
      end
      bmm_pkg::ST_MAC_ACC: begin
        cmd.op     = bmm_pkg::DP_ACC;
        j_next     = j + CW'(1);
        state_next = bmm_pkg::ST_MAC_ISSUE;
      end
      bmm_pkg::ST_MAC_CARRY: begin
        cmd.op = bmm_pkg::DP_CARRY;
        j_next = '0;
        if (AW'(i) + AW'(1) == nb) begin
          i_next = '0;
          unique case (pass)
            bmm_pkg::PASS_AB: begin
              pass_next  = bmm_pkg::PASS_MU;
              state_next = bmm_pkg::ST_MAC_ISSUE;
            end
            bmm_pkg::PASS_MU: begin
              pass_next  = bmm_pkg::PASS_N;
              state_next = bmm_pkg::ST_MAC_ISSUE;
            end
            default: begin
              state_next = bmm_pkg::ST_SUB_ISSUE;
            end
          endcase
        end else begin
          i_next     = i + CW'(1);
          state_next = bmm_pkg::ST_MAC_ISSUE;
        end
      end
      bmm_pkg::ST_SUB_ISSUE: begin
        cmd.op     = bmm_pkg::DP_SUB_ISSUE;
        state_next = bmm_pkg::ST_SUB_CALC;
      end
      bmm_pkg::ST_SUB_CALC: begin
        cmd.op = bmm_pkg::DP_SUB_CALC;
        if (j == k) begin
          j_next     = '0;
          state_next = bmm_pkg::ST_DIV_INIT;
        end else begin
          j_next     = j + CW'(1);
          state_next = bmm_pkg::ST_SUB_ISSUE;
        end
      end
      bmm_pkg::ST_DIV_INIT: begin
        if (status.n_nonzero) begin
          cmd.op         = bmm_pkg::DP_DIV_INIT;
          bits_left_next = BW'(k + CW'(1)) << bmm_pkg::LOG_LB;
          state_next     = bmm_pkg::ST_DIV_SHIFT;
        end else begin
          state_next = bmm_pkg::ST_EMIT;
        end
      end
      bmm_pkg::ST_DIV_SHIFT: begin
        cmd.op     = bmm_pkg::DP_DIV_SHIFT;
        j_next     = '0;
        state_next = bmm_pkg::ST_DIV_SUB;
      end
      bmm_pkg::ST_DIV_SUB: begin
        cmd.op = bmm_pkg::DP_DIV_SUB;
        if (j == k) begin
          j_next     = '0;
          state_next = bmm_pkg::ST_DIV_SEL;
        end else begin
          j_next = j + CW'(1);
        end
      end
      bmm_pkg::ST_DIV_SEL: begin
        cmd.op = bmm_pkg::DP_DIV_SEL;
        if (bits_left == BW'(1)) begin
          state_next = bmm_pkg::ST_EMIT;
        end else begin
          bits_left_next = bits_left - BW'(1);
          state_next     = bmm_pkg::ST_DIV_SHIFT;
        end
      end
      bmm_pkg::ST_EMIT: begin
        cmd.op = bmm_pkg::DP_EMIT;
        if (j == k - CW'(1)) begin
          j_next     = '0;
          state_next = bmm_pkg::ST_IDLE;
        end else begin
          j_next = j + CW'(1);
        end
      end
      default: begin
        state_next = bmm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/barrett_modular_multiply.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barrett_modular_multiply
// Barrett modular multiplication over 32-bit limbs: loads n, mu, a and b one
// limb at a time and on start streams out the k limbs of a*b mod n.
//
// Channel   Ports                      Transfer
// input     start, busy, item          start high and busy low at a clock edge
// result    done, result               every cycle that done is high
// config    cfg_we, cfg_data           every cycle that cfg_we is high
//
// A start runs three limb products on one shared 32x32 multiplier, a
// (k+1)-limb subtraction and, when n is nonzero, a bit-serial remainder of
// (k+1)*32 steps, then emits the k result limbs. Reset is synchronous and
// leaves the block idle with k = 16; the limb stores hold nothing until
// loaded. Results are not held off by the receiver.
// ----------------------------------------------------------------------------
module barrett_modular_multiply (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  bmm_pkg::item_t           item,
  output logic                     done,
  output bmm_pkg::result_t         result,
  input  wire                      cfg_we,
  input  wire [bmm_pkg::CFG_W-1:0] cfg_data
);

  bmm_pkg::ctrl_cmd_t  cmd;
  bmm_pkg::dp_status_t status;

  bmm_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  bmm_datapath u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

[src/bmm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmm_checker
// Port-level checks on the start transfer and the result run of the Barrett modular multiplier.
// ----------------------------------------------------------------------------
module bmm_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      start,
  input wire                      busy,
  input bmm_pkg::item_t           item,
  input wire                      done,
  input bmm_pkg::result_t         result
);

  a_done_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("Result transfer while the block is idle.");

  a_run_contiguous : assert property (@(posedge clk) disable iff (rst)
    done && !result.last_limb |=> done &&
      result.result_index == $past(result.result_index) + 4'd1)
    else $error("Result run broken or out of order.");

  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    done && result.last_limb |=> !busy)
    else $error("Block still busy after the last limb.");

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.opcode == bmm_pkg::OP_START |=> busy && !done)
    else $error("Start transfer did not begin a computation.");

endmodule

bind barrett_modular_multiply bmm_checker u_bmm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for barrett_modular_multiply. The limb stores are first
// filled, then a short table of directed loads and starts runs, and then
// random phases follow. Each phase sets the limb count, loads a modulus with
// its matching mu or random limbs, and issues starts. Every result limb is
// compared with a wide-vector Barrett model kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int NUM_ITEMS = 500;

  typedef logic [1151:0] wide_t;

  typedef struct {
    bmm_pkg::item_t it;
    bit             typed;
    logic [31:0]    limb;
  } drow_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bmm_pkg::item_t item = '0;
  logic done;
  bmm_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [bmm_pkg::CFG_W-1:0] cfg_data = '0;

  logic [31:0] modulus_shadow [bmm_pkg::MAX_LIMBS];
  logic [31:0] mu_shadow [bmm_pkg::MU_DEPTH];
  logic [31:0] a_shadow [bmm_pkg::MAX_LIMBS];
  logic [31:0] b_shadow [bmm_pkg::MAX_LIMBS];
  logic [bmm_pkg::CFG_W-1:0] limb_count = 5'd16;
  bmm_pkg::result_t pending_limbs [$];
  int errors = 0;
  int items_sent = 0;
  bit quiet = 1'b0;

  barrett_modular_multiply DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #(12.0 * 8000000);
    $display("Verification failed");
    $finish;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int active_limbs();
    if (limb_count == 0) return 1;
    if (limb_count > bmm_pkg::MAX_LIMBS) return bmm_pkg::MAX_LIMBS;
    return limb_count;
  endfunction

  function automatic void predict_transfer(input bmm_pkg::item_t it);
    wide_t x, q, t, r, n, mu, av, bv, mk;
    int k;
    bmm_pkg::result_t res;
    case (it.opcode)
      bmm_pkg::OP_LOAD_N:
        if (it.limb_index < bmm_pkg::MAX_LIMBS) modulus_shadow[it.limb_index] = it.limb_value;
      bmm_pkg::OP_LOAD_MU:
        if (it.limb_index < bmm_pkg::MU_DEPTH) mu_shadow[it.limb_index] = it.limb_value;
      bmm_pkg::OP_LOAD_A:
        if (it.limb_index < bmm_pkg::MAX_LIMBS) a_shadow[it.limb_index] = it.limb_value;
      bmm_pkg::OP_LOAD_B:
        if (it.limb_index < bmm_pkg::MAX_LIMBS) b_shadow[it.limb_index] = it.limb_value;
      bmm_pkg::OP_START: begin
        k = active_limbs();
        n = '0; mu = '0; av = '0; bv = '0;
        for (int i = 0; i < k; i++) begin
          n[32*i +: 32] = modulus_shadow[i];
          av[32*i +: 32] = a_shadow[i];
          bv[32*i +: 32] = b_shadow[i];
        end
        for (int i = 0; i <= k; i++) mu[32*i +: 32] = mu_shadow[i];
        mk = (wide_t'(1) << (32 * (k + 1))) - 1;
        x = av * bv;
        q = (x >> (32 * (k - 1))) & mk;
        q = ((q * mu) >> (32 * (k + 1))) & mk;
        t = (q * n) & mk;
        r = ((x & mk) - t) & mk;
        if (n != 0) r = r % n;
        for (int i = 0; i < k; i++) begin
          res.result_limb = r[32*i +: 32];
          res.result_index = 4'(i);
          res.last_limb = (i == k - 1);
          pending_limbs.insert(pending_limbs.size(), res);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_limbs.size() == 0) begin
        report($sformatf("unexpected limb %h index %0d", result.result_limb,
                         result.result_index));
      end else begin
        bmm_pkg::result_t want;
        want = pending_limbs.pop_front();
        if (result.result_limb !== want.result_limb)
          report($sformatf("limb %0d got %h want %h", want.result_index,
                           result.result_limb, want.result_limb));
        if (result.result_index !== want.result_index)
          report($sformatf("index got %0d want %0d", result.result_index,
                           want.result_index));
        if (result.last_limb !== want.last_limb)
          report($sformatf("last flag got %b want %b at index %0d",
                           result.last_limb, want.last_limb, want.result_index));
      end
    end
  end

  task automatic send(input bmm_pkg::item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_transfer(it);
    items_sent++;
  endtask

  task automatic send_op(input logic [2:0] op, input int idx, input logic [31:0] val);
    bmm_pkg::item_t it;
    it.opcode = op;
    it.limb_index = 5'(idx);
    it.limb_value = val;
    send(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_limbs.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_limb_count(input logic [bmm_pkg::CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limb_count = v;
  endtask

  function automatic logic [31:0] rand_limb();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_modulus_set(input int k);
    wide_t n, mu;
    n = '0;
    for (int i = 0; i < k; i++) n[32*i +: 32] = rand_limb();
    if (n[32*(k-1) +: 32] == 0) n[32*(k-1) +: 32] = $urandom | 32'h1;
    mu = (wide_t'(1) << (64 * k)) / n;
    for (int i = 0; i < k; i++) send_op(bmm_pkg::OP_LOAD_N, i, n[32*i +: 32]);
    for (int i = 0; i <= k; i++) send_op(bmm_pkg::OP_LOAD_MU, i, mu[32*i +: 32]);
  endtask

  task automatic run_table();
    drow_t rows [$];
    bmm_pkg::item_t it;
    bmm_pkg::result_t want;
    rows = '{
      '{'{bmm_pkg::OP_LOAD_A, 5'd0, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_START, 5'd0, 32'hFFFF_FFFF}, 1'b1, 32'h0},
      '{'{bmm_pkg::OP_LOAD_A, 5'd0, 32'hFFFF_FFFF}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_B, 5'd0, 32'hFFFF_FFFF}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_N, 5'd0, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_MU, 5'd0, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_MU, 5'd1, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_START, 5'd0, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_N, 5'd0, 32'hFFFF_FFFF}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_MU, 5'd0, 32'h1}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_MU, 5'd1, 32'h1}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_START, 5'd0, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_MU, 5'd1, 32'hFFFF_FFFF}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_START, 5'd0, 32'h0}, 1'b0, 32'h0},
      '{'{OP_RSVD5, 5'd0, 32'h1234_5678}, 1'b0, 32'h0},
      '{'{OP_RSVD6, 5'd31, 32'hFFFF_FFFF}, 1'b0, 32'h0},
      '{'{OP_RSVD7, 5'd16, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_N, 5'd16, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_B, 5'd31, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_MU, 5'd16, 32'hFFFF_FFFF}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_MU, 5'd17, 32'h0}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_LOAD_N, 5'd0, 32'h1}, 1'b0, 32'h0},
      '{'{bmm_pkg::OP_START, 5'd0, 32'h0}, 1'b1, 32'h0}
    };
    foreach (rows[r]) begin
      send(rows[r].it);
      if (rows[r].typed) begin
        want = pending_limbs[pending_limbs.size() - 1];
        if (want.result_limb !== rows[r].limb)
          report($sformatf("table row %0d model gives %h", r, want.result_limb));
      end
    end
  endtask

  initial begin
    int k;
    int sel;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < bmm_pkg::MAX_LIMBS; i++) begin
      send_op(bmm_pkg::OP_LOAD_N, i, rand_limb());
      send_op(bmm_pkg::OP_LOAD_A, i, rand_limb());
      send_op(bmm_pkg::OP_LOAD_B, i, rand_limb());
    end
    for (int i = 0; i < bmm_pkg::MU_DEPTH; i++) send_op(bmm_pkg::OP_LOAD_MU, i, rand_limb());
    send_op(bmm_pkg::OP_START, 0, 32'h0);
    set_limb_count(5'd1);
    run_table();
    while (items_sent < NUM_ITEMS) begin
      if (items_sent > NUM_ITEMS - 60) quiet = 1'b1;
      sel = $urandom_range(0, 11);
      case (sel)
        0: set_limb_count(5'd0);
        1: set_limb_count(5'd31);
        2: set_limb_count(5'd16);
        3: set_limb_count(5'($urandom_range(1, 31)));
        default: set_limb_count(5'($urandom_range(1, 5)));
      endcase
      k = active_limbs();
      if ($urandom_range(0, 3) != 0) begin
        load_modulus_set(k);
      end else begin
        repeat ($urandom_range(4, 12))
          send_op(3'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom);
      end
      repeat ($urandom_range(1, 3)) begin
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) != 0) send_op(bmm_pkg::OP_LOAD_A, i, rand_limb());
          if ($urandom_range(0, 3) != 0) send_op(bmm_pkg::OP_LOAD_B, i, rand_limb());
        end
        send_op(bmm_pkg::OP_START, $urandom_range(0, 31), $urandom);
      end
    end
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bmm_pkg.sv
src/bmm_datapath.sv
src/bmm_controller.sv
src/barrett_modular_multiply.sv
src/bmm_checker.sv
tb/sv/testbench.sv
